// ----- sv/spmv_pkg.sv -----
package spmv_pkg;

  localparam int DEF_MAX_DIM      = 64;
  localparam int DEF_MAX_NONZEROS = 1024;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int ROW_W    = 6;
  localparam int NUM_W    = 32;
  localparam int OFFSET_W = 11;
  localparam int DIM_W    = 7;

  localparam int ROW_COUNT = 1 << ROW_W;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic [KIND_W-1:0] KIND_X      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NZ     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd3;

  localparam logic signed [NUM_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [NUM_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_COL,
    S_COL_LAT,
    S_NZ,
    S_NZ_CHK,
    S_MUL,
    S_ACC,
    S_OUT,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic mul;
    logic rnd;
  } mac_ctrl_t;

endpackage

// ----- sv/csc_sparse_matrix_vector_multiply_unit.sv -----
// y = A*x for a square matrix in compressed sparse column form, Q16.16 signed values with
// saturating accumulation. Load items (x entry, column start, nonzero slot) are taken while idle.
// A run walks every column and each column's nonzeros through a single shared
// multiply-round-accumulate unit, then emits one result per row, last marked on the final row.
// Nonzeros whose row lies outside the effective dimension are skipped. Run length is set by the
// read-modify-write of the accumulator memory around the one multiplier; result transfers can
// stretch the output phase. Accumulators are cleared at once by per-row valid bits when a run
// is accepted.
module csc_sparse_matrix_vector_multiply_unit import spmv_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_W-1:0]       kind,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [ROW_W-1:0]        row_index,
  input  logic signed [NUM_W-1:0] number,
  input  logic [OFFSET_W-1:0]     offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row,
  output logic signed [NUM_W-1:0] out_value,
  output logic                    last
);

  localparam int X_AW      = $clog2(MAX_DIM);
  localparam int D_W       = $clog2(MAX_DIM + 1);
  localparam int NZ_AW     = $clog2(MAX_NONZEROS);
  localparam int NZ_CW     = $clog2(MAX_NONZEROS + 1);
  localparam int ACC_DEPTH = (MAX_DIM < ROW_COUNT) ? MAX_DIM : ROW_COUNT;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int NZ_DW     = ROW_W + NUM_W;

  state_t state, state_next;

  logic [DIM_W-1:0]     dimension;
  logic [D_W-1:0]       d_q, d_eff;
  logic [D_W-1:0]       c, r;
  logic [NZ_CW-1:0]     lo, hi, k, off_clamp;
  logic signed [NUM_W-1:0] mult;
  logic [ROW_W-1:0]     rr_q;
  logic [ACC_AW-1:0]    acc_raddr_q;
  logic [ACC_DEPTH-1:0] acc_vld;

  logic in_xfer, run_xfer, out_free, out_load;

  logic                 x_we, x_re;
  logic [X_AW-1:0]      x_raddr;
  logic [NUM_W-1:0]     x_rdata;
  logic                 cs_we, cs_re;
  logic [D_W-1:0]       cs_raddr;
  logic [OFFSET_W-1:0]  cs_rdata;
  logic                 nz_we, nz_re;
  logic [NZ_AW-1:0]     nz_raddr;
  logic [NZ_DW-1:0]     nz_rdata;
  logic [ROW_W-1:0]     nz_row;
  logic signed [NUM_W-1:0] nz_val;
  logic                 acc_we, acc_re;
  logic [ACC_AW-1:0]    acc_raddr;
  logic [NUM_W-1:0]     acc_rdata;
  logic signed [NUM_W-1:0] acc_in, acc_sum;
  logic                 row_ok, r_in_acc;
  mac_ctrl_t            mac_ctrl;

  assign in_xfer  = in_valid && in_ready;
  assign run_xfer = in_xfer && (kind == KIND_RUN);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (dimension == '0) begin
      d_eff = D_W'(1);
    end else if (32'(dimension) > 32'(MAX_DIM)) begin
      d_eff = D_W'(MAX_DIM);
    end else begin
      d_eff = D_W'(dimension);
    end
  end

  assign off_clamp = (32'(cs_rdata) > 32'(MAX_NONZEROS)) ? NZ_CW'(MAX_NONZEROS)
                                                          : NZ_CW'(cs_rdata);
  assign nz_row   = nz_rdata[NZ_DW-1:NUM_W];
  assign nz_val   = nz_rdata[NUM_W-1:0];
  assign row_ok   = 32'(nz_row) < 32'(d_q);
  assign r_in_acc = 32'(r) < 32'(ACC_DEPTH);
  assign acc_in   = acc_vld[acc_raddr_q] ? acc_rdata : '0;

  spmv_ram #(.WIDTH(NUM_W), .DEPTH(MAX_DIM)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (X_AW'(slot)),
    .wdata (number),
    .re    (x_re),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  spmv_ram #(.WIDTH(OFFSET_W), .DEPTH(MAX_DIM + 1)) u_cs_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (D_W'(slot)),
    .wdata (offset),
    .re    (cs_re),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  spmv_ram #(.WIDTH(NZ_DW), .DEPTH(MAX_NONZEROS)) u_nz_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (NZ_AW'(slot)),
    .wdata ({row_index, number}),
    .re    (nz_re),
    .raddr (nz_raddr),
    .rdata (nz_rdata)
  );

  spmv_ram #(.WIDTH(NUM_W), .DEPTH(ACC_DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (ACC_AW'(rr_q)),
    .wdata (acc_sum),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  spmv_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a      (nz_val),
    .b      (mult),
    .acc_in (acc_in),
    .sum    (acc_sum)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (run_xfer) state_next = S_START;
      S_START:   state_next = S_COL;
      S_COL:     state_next = S_COL_LAT;
      S_COL_LAT: state_next = S_NZ;
      S_NZ: begin
        if (k < hi) begin
          state_next = S_NZ_CHK;
        end else if (c + D_W'(1) == d_q) begin
          state_next = S_OUT;
        end else begin
          state_next = S_COL;
        end
      end
      S_NZ_CHK:  state_next = row_ok ? S_MUL : S_NZ;
      S_MUL:     state_next = S_ACC;
      S_ACC:     state_next = S_NZ;
      S_OUT:     state_next = S_OUT_LD;
      S_OUT_LD: begin
        if (out_free) begin
          state_next = (r + D_W'(1) == d_q) ? S_IDLE : S_OUT;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    x_we      = 1'b0;
    cs_we     = 1'b0;
    nz_we     = 1'b0;
    x_re      = 1'b0;
    x_raddr   = X_AW'(c);
    cs_re     = 1'b0;
    cs_raddr  = c + D_W'(1);
    nz_re     = 1'b0;
    nz_raddr  = NZ_AW'(k);
    acc_re    = 1'b0;
    acc_raddr = ACC_AW'(nz_row);
    acc_we    = 1'b0;
    mac_ctrl  = '0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        x_we     = in_xfer && (kind == KIND_X) && (32'(slot) < 32'(MAX_DIM));
        cs_we    = in_xfer && (kind == KIND_OFFSET) && (32'(slot) <= 32'(MAX_DIM));
        nz_we    = in_xfer && (kind == KIND_NZ) && (32'(slot) < 32'(MAX_NONZEROS));
        cs_re    = run_xfer;
        cs_raddr = '0;
      end
      S_COL: begin
        cs_re = 1'b1;
        x_re  = 1'b1;
      end
      S_NZ:     nz_re = k < hi;
      S_NZ_CHK: begin
        acc_re       = row_ok;
        mac_ctrl.mul = row_ok;
      end
      S_MUL:    mac_ctrl.rnd = 1'b1;
      S_ACC:    acc_we = 1'b1;
      S_OUT: begin
        acc_re    = r_in_acc;
        acc_raddr = ACC_AW'(r);
      end
      S_OUT_LD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dimension <= DIM_RESET;
      acc_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        dimension <= cfg_data;
      end
      if (run_xfer) begin
        acc_vld <= '0;
      end else if (acc_we) begin
        acc_vld[ACC_AW'(rr_q)] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_xfer) begin
      d_q <= d_eff;
      c   <= '0;
      r   <= '0;
    end
    if (acc_re) begin
      acc_raddr_q <= acc_raddr;
    end
    unique case (state)
      S_START: lo <= off_clamp;
      S_COL_LAT: begin
        hi   <= off_clamp;
        mult <= x_rdata;
        k    <= lo;
      end
      S_NZ: begin
        if (!(k < hi)) begin
          lo <= hi;
          c  <= c + D_W'(1);
        end
      end
      S_NZ_CHK: begin
        rr_q <= nz_row;
        if (!row_ok) begin
          k <= k + NZ_CW'(1);
        end
      end
      S_ACC: k <= k + NZ_CW'(1);
      S_OUT_LD: begin
        if (out_load) begin
          out_row   <= ROW_W'(r);
          out_value <= (r_in_acc && acc_vld[acc_raddr_q]) ? acc_rdata : '0;
          last      <= (r + D_W'(1) == d_q);
          r         <= r + D_W'(1);
        end
      end
      default: ;
    endcase
  end

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    run_xfer |=> acc_vld == '0)
    else $error("accumulator valid bits not cleared on run");

  a_nz_in_column: assert property (@(posedge clk) disable iff (rst)
    state == S_NZ_CHK |-> k < hi)
    else $error("nonzero read outside its column");

  a_acc_row_in_range: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> 32'(rr_q) < 32'(d_q))
    else $error("accumulator write to a row outside the matrix");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_load && (r + D_W'(1) == d_q) |=> state == S_IDLE && out_valid && last)
    else $error("final result transfer does not end the run");

endmodule

// ----- sv/spmv_ram.sv -----
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/spmv_mac.sv -----
module spmv_mac import spmv_pkg::*; (
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic signed [NUM_W-1:0] a,
  input  logic signed [NUM_W-1:0] b,
  input  logic signed [NUM_W-1:0] acc_in,
  output logic signed [NUM_W-1:0] sum
);

  logic signed [2*NUM_W-1:0] prod;
  logic signed [2*NUM_W-1:0] rsum;
  logic signed [NUM_W-1:0]   rnd;
  logic signed [NUM_W:0]     wide;

  // Q32.32 -> Q16.16, round half up, saturate
  assign rsum = prod + 64'sd32768;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= a * b;
    end
    if (ctrl.rnd) begin
      if ((&rsum[63:47]) || (~|rsum[63:47])) begin
        rnd <= rsum[47:16];
      end else if (rsum[63]) begin
        rnd <= Q_MIN;
      end else begin
        rnd <= Q_MAX;
      end
    end
  end

  assign wide = {acc_in[NUM_W-1], acc_in} + {rnd[NUM_W-1], rnd};

  always_comb begin
    if (wide[NUM_W] == wide[NUM_W-1]) begin
      sum = wide[NUM_W-1:0];
    end else if (wide[NUM_W]) begin
      sum = Q_MIN;
    end else begin
      sum = Q_MAX;
    end
  end

endmodule

// ----- sim/csc_sparse_matrix_vector_multiply_unit_tb.sv -----
`timescale 1ns / 100ps

module csc_sparse_matrix_vector_multiply_unit_tb import spmv_pkg::*;;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 250;
  localparam int LATENCY_PAD = 20;
  localparam int END_PAD = 64;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [63:0] WIDE_MAX = Q_MAX;
  localparam logic signed [63:0] WIDE_MIN = Q_MIN;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0] row;
    logic signed [NUM_W-1:0] number;
    logic [OFFSET_W-1:0] offset;
  } spmv_item_t;

  typedef struct packed {
    spmv_item_t item;
    logic typed;
    logic signed [NUM_W-1:0] want;
  } directed_row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic signed [NUM_W-1:0] value;
    logic final_row;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic [ROW_W-1:0] row_index = '0;
  logic signed [NUM_W-1:0] number = '0;
  logic [OFFSET_W-1:0] offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic signed [NUM_W-1:0] out_value;
  logic last;

  // predictor state
  logic signed [NUM_W-1:0] x_entries [DEF_MAX_DIM];
  logic [OFFSET_W-1:0] col_starts [DEF_MAX_DIM+1];
  logic [ROW_W-1:0] nz_rows [DEF_MAX_NONZEROS];
  logic signed [NUM_W-1:0] nz_values [DEF_MAX_NONZEROS];
  logic [DIM_W-1:0] dim_setting = DIM_RESET;
  bit x_set [DEF_MAX_DIM];
  bit start_set [DEF_MAX_DIM+1];
  bit nz_set [DEF_MAX_NONZEROS];

  row_result_t pending_rows [$];
  row_result_t head_row;
  int fail_count = 0;
  int useful_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  directed_row_t directed_plan [25] = '{
    '{'{KIND_X,      10'd0,    6'd0,  32'sh0001_0000, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_OFFSET, 10'd0,    6'd0,  32'sh0,         11'd0},    1'b0, 32'sh0},
    '{'{KIND_OFFSET, 10'd1,    6'd0,  32'sh0,         11'd1},    1'b0, 32'sh0},
    '{'{KIND_NZ,     10'd0,    6'd0,  Q_MAX,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, Q_MAX},
    '{'{KIND_X,      10'd0,    6'd0,  Q_MIN,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_NZ,     10'd0,    6'd0,  Q_MIN,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, Q_MAX},
    '{'{KIND_NZ,     10'd0,    6'd0,  Q_MAX,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, Q_MIN},
    '{'{KIND_X,      10'd0,    6'd0,  32'sh0000_0001, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_NZ,     10'd0,    6'd0,  32'sh0000_8000, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, 32'sh1},
    '{'{KIND_NZ,     10'd0,    6'd0,  32'shffff_8000, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, 32'sh0},
    '{'{KIND_NZ,     10'd0,    6'd63, Q_MAX,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, 32'sh0},
    '{'{KIND_X,      10'd1023, 6'd0,  Q_MAX,          11'd0},    1'b0, 32'sh0},
    '{'{KIND_NZ,     10'd1023, 6'd0,  32'sh0002_0000, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_OFFSET, 10'd0,    6'd0,  32'sh0,         11'd1023}, 1'b0, 32'sh0},
    '{'{KIND_OFFSET, 10'd1,    6'd0,  32'sh0,         11'd2047}, 1'b0, 32'sh0},
    '{'{KIND_X,      10'd0,    6'd0,  32'sh0003_0000, 11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b0, 32'sh0},
    '{'{KIND_OFFSET, 10'd1,    6'd0,  32'sh0,         11'd0},    1'b0, 32'sh0},
    '{'{KIND_RUN,    10'd0,    6'd0,  32'sh0,         11'd0},    1'b1, 32'sh0}
  };

  csc_sparse_matrix_vector_multiply_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .slot(slot),
    .row_index(row_index),
    .number(number),
    .offset(offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row(out_row),
    .out_value(out_value),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  function automatic int effective_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(v);
  endfunction

  function automatic int clamp_start(input logic [OFFSET_W-1:0] o);
    return (o > DEF_MAX_NONZEROS) ? DEF_MAX_NONZEROS : int'(o);
  endfunction

  function automatic logic signed [NUM_W-1:0] saturate(input logic signed [63:0] v);
    if (v > WIDE_MAX) return Q_MAX;
    if (v < WIDE_MIN) return Q_MIN;
    return v[NUM_W-1:0];
  endfunction

  // Q16.16 product, round half up, saturated
  function automatic logic signed [NUM_W-1:0] q_product(input logic signed [NUM_W-1:0] a,
                                                        input logic signed [NUM_W-1:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return saturate((wa * wb + 64'sd32768) >>> 16);
  endfunction

  task automatic multiply_matrix();
    logic signed [NUM_W-1:0] acc [DEF_MAX_DIM];
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    int d;
    int lo;
    int hi;
    row_result_t r;
    d = effective_dim(dim_setting);
    for (int i = 0; i < DEF_MAX_DIM; i++) acc[i] = '0;
    for (int c = 0; c < d; c++) begin
      lo = clamp_start(col_starts[c]);
      hi = clamp_start(col_starts[c+1]);
      for (int k = lo; k < hi; k++) begin
        if (int'(nz_rows[k]) < d) begin
          wa = acc[nz_rows[k]];
          wb = q_product(nz_values[k], x_entries[c]);
          acc[nz_rows[k]] = saturate(wa + wb);
        end
      end
    end
    for (int i = 0; i < d; i++) begin
      r.row = ROW_W'(i);
      r.value = acc[i];
      r.final_row = (i == d - 1);
      pending_rows.push_back(r);
    end
  endtask

  task automatic absorb_item(input spmv_item_t it, input bit typed,
                             input logic signed [NUM_W-1:0] want);
    row_result_t r;
    case (it.kind)
      KIND_X: begin
        if (it.slot < DEF_MAX_DIM) begin
          x_entries[it.slot] = it.number;
          x_set[it.slot] = 1'b1;
          useful_items++;
        end
      end
      KIND_OFFSET: begin
        if (it.slot <= DEF_MAX_DIM) begin
          col_starts[it.slot] = it.offset;
          start_set[it.slot] = 1'b1;
          useful_items++;
        end
      end
      KIND_NZ: begin
        nz_rows[it.slot] = it.row;
        nz_values[it.slot] = it.number;
        nz_set[it.slot] = 1'b1;
        useful_items++;
      end
      KIND_RUN: begin
        useful_items++;
        if (typed) begin
          r.row = '0;
          r.value = want;
          r.final_row = 1'b1;
          pending_rows.push_back(r);
        end else begin
          multiply_matrix();
        end
      end
    endcase
  endtask

  task automatic send_item(input spmv_item_t it, input bit typed,
                           input logic signed [NUM_W-1:0] want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    slot <= it.slot;
    row_index <= it.row;
    number <= it.number;
    offset <= it.offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_item(it, typed, want);
  endtask

  // sender pauses until every pending row result has been transferred
  task automatic settle(input int pad);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_dimension(input logic [DIM_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    dim_setting = v;
  endtask

  function automatic logic signed [NUM_W-1:0] rand_number();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: return $signed(NUM_W'($urandom_range(0, 'h7_ffff))) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic spmv_item_t scrambled_item(input logic [KIND_W-1:0] k);
    spmv_item_t it;
    it.kind = k;
    it.slot = SLOT_W'($urandom);
    it.row = ROW_W'($urandom);
    it.number = $urandom;
    it.offset = OFFSET_W'($urandom);
    return it;
  endfunction

  function automatic spmv_item_t noise_item();
    spmv_item_t it;
    case ($urandom_range(0, 2))
      0: begin
        it = scrambled_item(KIND_X);
        it.slot = SLOT_W'($urandom_range(DEF_MAX_DIM, 1023));
      end
      1: begin
        it = scrambled_item(KIND_OFFSET);
        it.slot = SLOT_W'($urandom_range(DEF_MAX_DIM + 1, 1023));
      end
      default: begin
        it = scrambled_item(KIND_NZ);
        it.number = rand_number();
      end
    endcase
    return it;
  endfunction

  // one matrix load followed by a run; only entries the run reads must be written
  task automatic run_sequence(input int de, input bit hold);
    spmv_item_t it;
    bit fresh;
    int cur;
    int lo;
    int hi;
    fresh = 1'b0;
    for (int c = 0; c <= de; c++) if (!start_set[c]) fresh = 1'b1;
    // starts left over from layouts of other sizes can span long columns
    for (int c = 0; c < de; c++)
      if (start_set[c] && start_set[c+1] &&
          clamp_start(col_starts[c+1]) - clamp_start(col_starts[c]) > 3) fresh = 1'b1;
    if (fresh || $urandom_range(0, (de > 16) ? 5 : 2) == 0) begin
      cur = ($urandom_range(0, 5) == 0) ? $urandom_range(1000, 1023)
                                        : $urandom_range(0, 1023 - 4 * de);
      for (int c = 0; c <= de; c++) begin
        it = scrambled_item(KIND_OFFSET);
        it.slot = SLOT_W'(c);
        it.offset = (cur >= DEF_MAX_NONZEROS && $urandom_range(0, 1) == 0) ?
                    OFFSET_W'($urandom_range(DEF_MAX_NONZEROS, 2047)) : OFFSET_W'(cur);
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 9) == 0) cur -= $urandom_range(0, (cur < 3) ? cur : 3);
        else if (de > 16) cur += ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
        else cur += $urandom_range(0, 3);
      end
    end
    for (int c = 0; c < de; c++) begin
      lo = clamp_start(col_starts[c]);
      hi = clamp_start(col_starts[c+1]);
      for (int k = lo; k < hi; k++) begin
        if (!nz_set[k] || $urandom_range(0, 2) == 0) begin
          it = scrambled_item(KIND_NZ);
          it.slot = SLOT_W'(k);
          it.row = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom)
                                               : ROW_W'($urandom_range(0, de - 1));
          it.number = rand_number();
          send_item(it, 1'b0, '0);
        end
      end
    end
    for (int c = 0; c < de; c++) begin
      if (!x_set[c] || $urandom_range(0, (de > 16) ? 7 : 1) == 0) begin
        it = scrambled_item(KIND_X);
        it.slot = SLOT_W'(c);
        it.number = rand_number();
        send_item(it, 1'b0, '0);
      end
    end
    repeat ($urandom_range(0, 2)) send_item(noise_item(), 1'b0, '0);
    send_item(scrambled_item(KIND_RUN), 1'b0, '0);
    if (hold || $urandom_range(0, 19) == 0) hold_toggle <= ~hold_toggle;
  endtask

  task automatic matrix_phase(input logic [DIM_W-1:0] v, input int budget, input bit hold);
    int first;
    int de;
    settle(LATENCY_PAD);
    write_dimension(v);
    de = effective_dim(v);
    first = useful_items;
    do begin
      run_sequence(de, hold);
      hold = 1'b0;
      if ($urandom_range(0, 5) == 0) settle(0);
    end while (useful_items - first < budget);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        note_failure($sformatf("unexpected transfer: row %0d value %h last %b",
                               out_row, out_value, last));
      end else begin
        head_row = pending_rows.pop_front();
        if (out_row !== head_row.row || out_value !== head_row.value ||
            last !== head_row.final_row)
          note_failure($sformatf("exp row %0d value %h last %b, got row %0d value %h last %b",
                                 head_row.row, head_row.value, head_row.final_row,
                                 out_row, out_value, last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("csc_sparse_matrix_vector_multiply_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 54;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_dimension(DIM_W'(1));
    foreach (directed_plan[i])
      send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);

    matrix_phase(DIM_W'(6), 40, 1'b0);
    matrix_phase(DIM_W'(0), 15, 1'b0);
    matrix_phase(DIM_W'(64), 1, 1'b1);

    send_idle_pct = 54;
    recv_idle_pct = 38;
    matrix_phase(DIM_W'(127), 1, 1'b0);
    matrix_phase(DIM_W'(3), 30, 1'b0);
    matrix_phase(DIM_W'(17), 40, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    matrix_phase(DIM_W'(2), 25, 1'b0);
    matrix_phase(DIM_W'(9), 30, 1'b1);
    matrix_phase(DIM_W'(100), 1, 1'b0);

    settle(END_PAD);
    if (pending_rows.size() != 0)
      note_failure($sformatf("%0d row results never transferred", pending_rows.size()));
    if (fail_count == 0) begin
      $display("csc_sparse_matrix_vector_multiply_unit regression: pass");
    end else begin
      $display("csc_sparse_matrix_vector_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
